// File: rtl/core/dual_axis_min_jerk_trajectory_macros.svh
// Assertion macros for the trajectory checker.
`ifndef DUAL_AXIS_MIN_JERK_TRAJECTORY_MACROS_SVH
`define DUAL_AXIS_MIN_JERK_TRAJECTORY_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define DAMJ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("damj_chk: property failed");

// Consequent checked in the cycle after the antecedent.
`define DAMJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("damj_chk: property failed");

// Consequent checked later, after the delay given by dly.
`define DAMJ_ASSERT_LATER(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("damj_chk: property failed");

`endif

// File: rtl/core/damj_pkg.sv
`timescale 1ns / 1ps

package damj_pkg;

    // Data widths
    localparam int ANGLE_WIDTH        = 32;
    localparam int PROGRESS_FRAC_BITS = 16;
    localparam int OP_W               = 2;
    localparam int TIME_W             = 32;
    localparam int MT_W               = 16;
    localparam int STATUS_W           = 2;

    // Derived arithmetic widths
    localparam int K_W     = PROGRESS_FRAC_BITS + 1;       // progress, 0..ONE
    localparam int KK_W    = 2 * PROGRESS_FRAC_BITS + 1;   // k*k
    localparam int KK6_W   = KK_W + 2;                     // 6*k*k
    localparam int SIX_W   = KK6_W - PROGRESS_FRAC_BITS;   // 6*k*k / ONE
    localparam int INNER_W = PROGRESS_FRAC_BITS + 4;       // 10 - 15p + 6p^2, up to 10*ONE
    localparam int MAG_W   = ANGLE_WIDTH + 1;              // |goal - start|
    localparam int MC_W    = (MAG_W > INNER_W) ? MAG_W : INNER_W;
    localparam int MP_W    = K_W;
    localparam int PROD_W  = MC_W + MP_W;
    localparam int BL_W    = PROD_W - PROGRESS_FRAC_BITS;
    localparam int MUL_CNT_W = $clog2(MP_W + 1);
    localparam int DIV_CNT_W = $clog2(PROGRESS_FRAC_BITS + 1);

    typedef logic signed [ANGLE_WIDTH-1:0]  t_angle;
    typedef logic [K_W-1:0]                 t_prog;
    typedef logic [MC_W-1:0]                t_mcand;
    typedef logic [MP_W-1:0]                t_mplier;
    typedef logic [PROD_W-1:0]              t_prod;
    typedef logic [MUL_CNT_W-1:0]           t_mul_cnt;
    typedef logic [DIV_CNT_W-1:0]           t_div_cnt;
    typedef logic [PROGRESS_FRAC_BITS-1:0]  t_quot;
    typedef logic [MT_W-1:0]                t_mtime;
    typedef logic [OP_W-1:0]                t_op;
    typedef logic [STATUS_W-1:0]            t_status;

    // Operation codes
    localparam t_op OP_TICK  = 2'd0;
    localparam t_op OP_START = 2'd1;
    localparam t_op OP_STOP  = 2'd2;
    localparam t_op OP_CLEAR = 2'd3;

    // Status codes
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOTHING = 2'd1;
    localparam t_status ST_REJECT  = 2'd2;

    // Constants
    localparam t_prog    P_ONE           = {1'b1, {PROGRESS_FRAC_BITS{1'b0}}};
    localparam logic [INNER_W-1:0] TEN_ONE = {4'd10, {PROGRESS_FRAC_BITS{1'b0}}};
    localparam t_mtime   MOVE_TIME_RESET = 16'd2000;
    localparam t_mul_cnt MUL_STEPS       = t_mul_cnt'(MP_W);
    localparam t_div_cnt DIV_STEPS       = t_div_cnt'(PROGRESS_FRAC_BITS);

    // Multiplier request
    typedef struct packed {
        logic    go;
        t_mcand  mcand;
        t_mplier mplier;
    } t_mul_req;

    // Divider request
    typedef struct packed {
        logic   go;
        t_mtime num;
        t_mtime den;
    } t_div_req;

endpackage

// File: rtl/core/damj_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// Computes floor(num * 2^PROGRESS_FRAC_BITS / den) for num < den.
module damj_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  damj_pkg::t_div_req i_req,
    output logic              o_done,
    output damj_pkg::t_quot   o_quot
);

    logic                        r_busy;
    logic                        r_done;
    damj_pkg::t_div_cnt          r_cnt;
    damj_pkg::t_mtime            r_rem;
    damj_pkg::t_mtime            r_den;
    damj_pkg::t_quot             r_quot;

    logic [damj_pkg::MT_W:0]     w_sh;
    logic [damj_pkg::MT_W:0]     w_diff;
    logic                        w_ge;

    // Shift remainder, trial subtract
    always_comb begin
        w_sh   = {r_rem, 1'b0};
        w_ge   = (w_sh >= {1'b0, r_den});
        w_diff = w_sh - {1'b0, r_den};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= damj_pkg::DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - damj_pkg::t_div_cnt'(1);
                if (r_cnt == damj_pkg::t_div_cnt'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[damj_pkg::MT_W-1:0] : w_sh[damj_pkg::MT_W-1:0];
            r_quot <= {r_quot[damj_pkg::PROGRESS_FRAC_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/core/damj_smul.sv
`timescale 1ns / 1ps

// Serial-parallel shift-add multiplier, one multiplier bit per cycle.
module damj_smul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  damj_pkg::t_mul_req i_req,
    output logic               o_done,
    output damj_pkg::t_prod    o_prod
);

    logic                        r_busy;
    logic                        r_done;
    damj_pkg::t_mul_cnt          r_cnt;
    damj_pkg::t_mcand            r_mc;
    damj_pkg::t_prod             r_prod;

    logic [damj_pkg::MC_W:0]     w_sum;

    // Add multiplicand into upper half when the low bit is set
    always_comb begin
        w_sum = {1'b0, r_prod[damj_pkg::PROD_W-1:damj_pkg::MP_W]}
              + (r_prod[0] ? {1'b0, r_mc} : '0);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= damj_pkg::MUL_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - damj_pkg::t_mul_cnt'(1);
                if (r_cnt == damj_pkg::t_mul_cnt'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Product shift register: multiplier bits shift out at the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_mc   <= i_req.mcand;
            r_prod <= {{damj_pkg::MC_W{1'b0}}, i_req.mplier};
        end else if (r_busy) begin
            r_prod <= {w_sum, r_prod[damj_pkg::MP_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// File: rtl/core/dual_axis_min_jerk_trajectory.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Carries
// input     in         i_in_valid / o_in_stall    operation, now_ms, targets, move_allowed
// output    out        o_out_valid / i_out_stall  commands, command_valid, running, status
// config    in         i_cfg_valid / o_cfg_ready  move_time_ms
//
// One transaction at a time. Start, stop, clear and an idle tick pass from acceptance
// through S_EXEC to S_FIN. A running tick goes through a bit-serial divider for progress,
// then four passes of the shift-add multiplier (k*k, p^2*k, p^3*inner, both axes in
// parallel), one bit a cycle.
// Reset is synchronous and clears all coordinates and the run flag; the move time resets to 2000.
// The next transaction is accepted while a result waits in the output register; a result
// is written only once the output register is free.
module dual_axis_min_jerk_trajectory (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  damj_pkg::t_op       i_operation,
    input  logic [damj_pkg::TIME_W-1:0] i_now_ms,
    input  damj_pkg::t_angle    i_target_left,
    input  damj_pkg::t_angle    i_target_right,
    input  logic                i_move_allowed,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output damj_pkg::t_angle    o_command_left,
    output damj_pkg::t_angle    o_command_right,
    output logic                o_command_valid,
    output logic                o_running,
    output damj_pkg::t_status   o_status,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  damj_pkg::t_mtime    i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_KK   = 3'd3;
    localparam logic [2:0] S_P3   = 3'd4;
    localparam logic [2:0] S_BL   = 3'd5;
    localparam logic [2:0] S_AX   = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    localparam int PF  = damj_pkg::PROGRESS_FRAC_BITS;
    localparam int AW  = damj_pkg::ANGLE_WIDTH;
    localparam int MGW = damj_pkg::MAG_W;
    localparam int IW  = damj_pkg::INNER_W;

    // Control and architectural state
    logic [2:0]                  r_state, n_state;
    logic                        r_div_go, n_div_go;
    logic                        r_mul_go, n_mul_go;
    logic                        r_ax_go, n_ax_go;
    logic                        r_out_valid;
    logic                        r_run, n_run;
    damj_pkg::t_mtime            r_move_time;
    damj_pkg::t_angle            r_start_l, n_start_l, r_start_r, n_start_r;
    damj_pkg::t_angle            r_goal_l, n_goal_l, r_goal_r, n_goal_r;
    damj_pkg::t_angle            r_cur_l, n_cur_l, r_cur_r, n_cur_r;
    logic [damj_pkg::TIME_W-1:0] r_t0, n_t0;

    // Latched transaction
    damj_pkg::t_op               r_op;
    logic [damj_pkg::TIME_W-1:0] r_now;
    damj_pkg::t_angle            r_tgt_l, r_tgt_r;
    logic                        r_allow;

    // Working registers
    logic                        r_sat;
    damj_pkg::t_mtime            r_elapsed;
    damj_pkg::t_prog             r_k, r_p2, r_p3, r_blend;
    logic [IW-1:0]               r_inner;
    damj_pkg::t_angle            r_new_l, r_new_r;
    logic                        r_o_cmd_valid, n_cmd_valid;
    damj_pkg::t_status           r_o_status, n_status;

    // Interconnect
    logic                        w_in_fire, w_out_free, w_fin_fire;
    logic [damj_pkg::TIME_W-1:0] w_elapsed;
    logic                        w_sat;
    damj_pkg::t_div_req          w_div_req;
    logic                        w_div_done;
    damj_pkg::t_quot             w_quot;
    damj_pkg::t_mul_req          w_mul_req, w_ax_req_l, w_ax_req_r;
    logic                        w_mul_done, w_done_l, w_done_r, w_ax_done;
    damj_pkg::t_prod             w_mul_prod, w_prod_l, w_prod_r;
    logic [damj_pkg::KK_W-1:0]   w_kk;
    logic [damj_pkg::KK6_W-1:0]  w_kk6;
    logic [damj_pkg::SIX_W-1:0]  w_six;
    logic [IW:0]                 w_k15, w_inner_sum;
    logic [damj_pkg::BL_W-1:0]   w_bl;
    logic [MGW-1:0]              w_d_l, w_d_r, w_mag_l, w_mag_r;
    logic [MGW-1:0]              w_delta_l, w_delta_r, w_sum_l, w_sum_r;

    // Handshakes
    assign w_in_fire  = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fin_fire = (r_state == S_FIN) && w_out_free;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Elapsed time and saturation
    assign w_elapsed = r_now - r_t0;
    assign w_sat     = (w_elapsed >= {{(damj_pkg::TIME_W - damj_pkg::MT_W){1'b0}}, r_move_time});

    // Progress divider
    assign w_div_req.go  = r_div_go;
    assign w_div_req.num = r_elapsed;
    assign w_div_req.den = r_move_time;

    damj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Shared multiplier operand select for the blend polynomial
    always_comb begin
        w_mul_req.go     = r_mul_go;
        w_mul_req.mcand  = '0;
        w_mul_req.mplier = '0;
        case (r_state)
            S_KK: begin
                w_mul_req.mcand  = damj_pkg::t_mcand'(r_k);
                w_mul_req.mplier = damj_pkg::t_mplier'(r_k);
            end
            S_P3: begin
                w_mul_req.mcand  = damj_pkg::t_mcand'(r_p2);
                w_mul_req.mplier = damj_pkg::t_mplier'(r_k);
            end
            S_BL: begin
                w_mul_req.mcand  = damj_pkg::t_mcand'(r_inner);
                w_mul_req.mplier = damj_pkg::t_mplier'(r_p3);
            end
            default: ;
        endcase
    end

    damj_smul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    // Inner term: 10*ONE - 15k + floor(6*k*k / ONE)
    always_comb begin
        w_kk        = w_mul_prod[damj_pkg::KK_W-1:0];
        w_kk6       = {w_kk, 2'b00} + {1'b0, w_kk, 1'b0};
        w_six       = w_kk6[damj_pkg::KK6_W-1:PF];
        w_k15       = {r_k, 4'b0000} - {4'b0000, r_k};
        w_inner_sum = {1'b0, damj_pkg::TEN_ONE} + {2'b00, w_six} - w_k15;
        w_bl        = w_mul_prod[damj_pkg::PROD_W-1:PF];
    end

    // Per-axis difference magnitude
    always_comb begin
        w_d_l   = {r_goal_l[AW-1], r_goal_l} - {r_start_l[AW-1], r_start_l};
        w_d_r   = {r_goal_r[AW-1], r_goal_r} - {r_start_r[AW-1], r_start_r};
        w_mag_l = w_d_l[MGW-1] ? (~w_d_l + MGW'(1)) : w_d_l;
        w_mag_r = w_d_r[MGW-1] ? (~w_d_r + MGW'(1)) : w_d_r;
    end

    assign w_ax_req_l.go     = r_ax_go;
    assign w_ax_req_l.mcand  = damj_pkg::t_mcand'(w_mag_l);
    assign w_ax_req_l.mplier = damj_pkg::t_mplier'(r_blend);
    assign w_ax_req_r.go     = r_ax_go;
    assign w_ax_req_r.mcand  = damj_pkg::t_mcand'(w_mag_r);
    assign w_ax_req_r.mplier = damj_pkg::t_mplier'(r_blend);

    damj_smul u_mul_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ax_req_l),
        .o_done  (w_done_l),
        .o_prod  (w_prod_l)
    );

    damj_smul u_mul_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ax_req_r),
        .o_done  (w_done_r),
        .o_prod  (w_prod_r)
    );

    assign w_ax_done = w_done_l && w_done_r;

    // New command: start +/- floor(|d| * blend / ONE)
    always_comb begin
        w_delta_l = w_prod_l[PF +: MGW];
        w_delta_r = w_prod_r[PF +: MGW];
        w_sum_l   = w_d_l[MGW-1] ? ({r_start_l[AW-1], r_start_l} - w_delta_l)
                                 : ({r_start_l[AW-1], r_start_l} + w_delta_l);
        w_sum_r   = w_d_r[MGW-1] ? ({r_start_r[AW-1], r_start_r} - w_delta_r)
                                 : ({r_start_r[AW-1], r_start_r} + w_delta_r);
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_div_go = 1'b0;
        n_mul_go = 1'b0;
        n_ax_go  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) n_state = S_EXEC;
            end
            S_EXEC: begin
                if ((r_op == damj_pkg::OP_TICK) && r_run) begin
                    n_state  = S_DIV;
                    n_div_go = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state  = S_KK;
                    n_mul_go = 1'b1;
                end
            end
            S_KK: begin
                if (w_mul_done) begin
                    n_state  = S_P3;
                    n_mul_go = 1'b1;
                end
            end
            S_P3: begin
                if (w_mul_done) begin
                    n_state  = S_BL;
                    n_mul_go = 1'b1;
                end
            end
            S_BL: begin
                if (w_mul_done) begin
                    n_state = S_AX;
                    n_ax_go = 1'b1;
                end
            end
            S_AX: begin
                if (w_ax_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Operation decode at completion
    always_comb begin
        n_run       = r_run;
        n_start_l   = r_start_l;
        n_start_r   = r_start_r;
        n_goal_l    = r_goal_l;
        n_goal_r    = r_goal_r;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_t0        = r_t0;
        n_cmd_valid = 1'b0;
        n_status    = damj_pkg::ST_OK;
        unique case (r_op)
            damj_pkg::OP_TICK: begin
                if (r_run) begin
                    n_cur_l     = r_new_l;
                    n_cur_r     = r_new_r;
                    n_cmd_valid = 1'b1;
                    if (r_sat) n_run = 1'b0;
                end else begin
                    n_status = damj_pkg::ST_NOTHING;
                end
            end
            damj_pkg::OP_START: begin
                if (r_allow) begin
                    n_goal_l  = r_tgt_l;
                    n_goal_r  = r_tgt_r;
                    n_start_l = r_cur_l;
                    n_start_r = r_cur_r;
                    n_t0      = r_now;
                    n_run     = 1'b1;
                end else begin
                    n_status = damj_pkg::ST_REJECT;
                end
            end
            damj_pkg::OP_STOP: begin
                n_run = 1'b0;
            end
            damj_pkg::OP_CLEAR: begin
                n_start_l = '0;
                n_start_r = '0;
                n_goal_l  = '0;
                n_goal_r  = '0;
                n_cur_l   = '0;
                n_cur_r   = '0;
                n_run     = 1'b0;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_go    <= 1'b0;
            r_mul_go    <= 1'b0;
            r_ax_go     <= 1'b0;
            r_out_valid <= 1'b0;
            r_run       <= 1'b0;
            r_move_time <= damj_pkg::MOVE_TIME_RESET;
            r_start_l   <= '0;
            r_start_r   <= '0;
            r_goal_l    <= '0;
            r_goal_r    <= '0;
            r_cur_l     <= '0;
            r_cur_r     <= '0;
            r_t0        <= '0;
        end else begin
            r_state  <= n_state;
            r_div_go <= n_div_go;
            r_mul_go <= n_mul_go;
            r_ax_go  <= n_ax_go;
            if (i_cfg_valid) r_move_time <= i_cfg_data;
            if (w_fin_fire) begin
                r_out_valid <= 1'b1;
                r_run       <= n_run;
                r_start_l   <= n_start_l;
                r_start_r   <= n_start_r;
                r_goal_l    <= n_goal_l;
                r_goal_r    <= n_goal_r;
                r_cur_l     <= n_cur_l;
                r_cur_r     <= n_cur_r;
                r_t0        <= n_t0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op    <= i_operation;
            r_now   <= i_now_ms;
            r_tgt_l <= i_target_left;
            r_tgt_r <= i_target_right;
            r_allow <= i_move_allowed;
        end
        if (r_state == S_EXEC) begin
            r_sat     <= w_sat;
            r_elapsed <= w_elapsed[damj_pkg::MT_W-1:0];
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_k <= r_sat ? damj_pkg::P_ONE : {1'b0, w_quot};
        end
        if ((r_state == S_KK) && w_mul_done) begin
            r_p2    <= w_mul_prod[PF +: damj_pkg::K_W];
            r_inner <= w_inner_sum[IW-1:0];
        end
        if ((r_state == S_P3) && w_mul_done) begin
            r_p3 <= w_mul_prod[PF +: damj_pkg::K_W];
        end
        if ((r_state == S_BL) && w_mul_done) begin
            // blend clamps at one
            if (w_bl > {{(damj_pkg::BL_W - damj_pkg::K_W){1'b0}}, damj_pkg::P_ONE})
                r_blend <= damj_pkg::P_ONE;
            else
                r_blend <= w_bl[damj_pkg::K_W-1:0];
        end
        if ((r_state == S_AX) && w_ax_done) begin
            r_new_l <= w_sum_l[AW-1:0];
            r_new_r <= w_sum_r[AW-1:0];
        end
        if (w_fin_fire) begin
            r_o_cmd_valid <= n_cmd_valid;
            r_o_status    <= n_status;
        end
    end

    // Outputs: commands and run flag change only when a result is written
    assign o_out_valid     = r_out_valid;
    assign o_command_left  = r_cur_l;
    assign o_command_right = r_cur_r;
    assign o_command_valid = r_o_cmd_valid;
    assign o_running       = r_run;
    assign o_status        = r_o_status;

endmodule

// File: rtl/core/damj_chk.sv
`timescale 1ns / 1ps

`include "dual_axis_min_jerk_trajectory_macros.svh"

// Port-level checker for the trajectory block.
module damj_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input damj_pkg::t_op       i_operation,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input damj_pkg::t_angle    o_command_left,
    input damj_pkg::t_angle    o_command_right,
    input logic                o_command_valid,
    input logic                o_running,
    input damj_pkg::t_status   o_status
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // New commands only come with an ok status
    `DAMJ_ASSERT_NOW(a_cmd_ok, i_clk, i_rst_n, o_out_valid && o_command_valid,
                     o_status == damj_pkg::ST_OK)

    // One transaction in flight: stall right after acceptance
    `DAMJ_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, w_in_acc, o_in_stall)

    // Stalled result holds
    `DAMJ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
                      o_out_valid && $stable(o_command_left) && $stable(o_status))

    // Stop ends the run without a new command
    `DAMJ_ASSERT_LATER(a_stop, i_clk, i_rst_n,
                       w_in_acc && (i_operation == damj_pkg::OP_STOP) && !o_out_valid, 3,
                       o_out_valid && !o_running && !o_command_valid)

    // Clear zeroes both commands
    `DAMJ_ASSERT_LATER(a_clear, i_clk, i_rst_n,
                       w_in_acc && (i_operation == damj_pkg::OP_CLEAR) && !o_out_valid, 3,
                       o_out_valid && !o_running && (o_command_left == '0)
                       && (o_command_right == '0))

endmodule

bind dual_axis_min_jerk_trajectory damj_chk u_damj_chk (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import damj_pkg::*;

    localparam int     FB          = PROGRESS_FRAC_BITS;
    localparam int     QUIET_LIMIT = 4000;
    localparam int     TAIL_CYCLES = 120;
    localparam t_angle ANG_MAX     = 32'sh7FFF_FFFF;
    localparam t_angle ANG_MIN     = 32'sh8000_0000;
    localparam bit     TYPED       = 1'b1;
    localparam bit     PREDICTED   = 1'b0;

    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] now;
        t_angle            left;
        t_angle            right;
        logic              allowed;
    } motion_req_t;

    typedef struct packed {
        t_angle  left;
        t_angle  right;
        logic    fresh;
        logic    running;
        t_status status;
    } motion_rsp_t;

    typedef struct {
        motion_req_t req;
        bit          has_fixed;
        motion_rsp_t fixed_rsp;
    } bringup_row_t;

    // DUT ports
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_op               i_operation;
    logic [TIME_W-1:0] i_now_ms;
    t_angle            i_target_left;
    t_angle            i_target_right;
    logic              i_move_allowed;
    logic              o_out_valid;
    logic              i_out_stall;
    t_angle            o_command_left;
    t_angle            o_command_right;
    logic              o_command_valid;
    logic              o_running;
    t_status           o_status;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    t_mtime            i_cfg_data;

    // Trajectory state mirrored by the predictor
    t_angle            traj_from_l, traj_from_r;
    t_angle            traj_goal_l, traj_goal_r;
    t_angle            cmd_l, cmd_r;
    logic [TIME_W-1:0] traj_t0;
    logic              traj_run;
    t_mtime            move_time;

    motion_rsp_t       pending_commands[$];
    bringup_row_t      bringup_rows[$];
    logic [TIME_W-1:0] wall_ms;
    bit                no_idle = 1'b0;
    int                errors = 0;
    int                items_sent = 0;
    int                results_checked = 0;
    int                moves_finished = 0;
    int                settings_used = 0;
    int                quiet_cycles = 0;

    dual_axis_min_jerk_trajectory u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_now_ms        (i_now_ms),
        .i_target_left   (i_target_left),
        .i_target_right  (i_target_right),
        .i_move_allowed  (i_move_allowed),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_command_left  (o_command_left),
        .o_command_right (o_command_right),
        .o_command_valid (o_command_valid),
        .o_running       (o_running),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // p^3 * (10 - 15p + 6p^2) in Q1.FB, capped at one
    function automatic logic [K_W-1:0] quintic_blend(logic [K_W-1:0] k);
        longint unsigned one = 64'd1 << FB;
        longint unsigned kk = 64'(k);
        longint unsigned p2, p3, inner, b;
        p2    = (kk * kk) >> FB;
        p3    = (p2 * kk) >> FB;
        inner = 10 * one + ((6 * kk * kk) >> FB) - 15 * kk;
        b     = (p3 * inner) >> FB;
        if (b > one) begin
            b = one;
        end
        return K_W'(b);
    endfunction

    // src + (dst - src) * b, magnitude scaled then sign restored
    function automatic t_angle blend_axis(t_angle src, t_angle dst, logic [K_W-1:0] b);
        longint          d = longint'(dst) - longint'(src);
        longint unsigned mag = (d < 0) ? -d : d;
        longint unsigned span;
        span = (mag >> FB) * b + (((mag & ((64'd1 << FB) - 1)) * b) >> FB);
        if (d < 0) begin
            return t_angle'(longint'(src) - longint'(span));
        end
        return t_angle'(longint'(src) + longint'(span));
    endfunction

    // Expected result of one transaction; advances the mirrored state
    function automatic motion_rsp_t step_trajectory(motion_req_t r);
        motion_rsp_t       rsp;
        logic [TIME_W-1:0] elapsed;
        logic [K_W-1:0]    k, b;
        rsp.fresh  = 1'b0;
        rsp.status = ST_OK;
        case (r.op)
            OP_TICK: begin
                if (traj_run) begin
                    elapsed = r.now - traj_t0;
                    if (move_time == '0 || elapsed >= move_time) begin
                        k = P_ONE;
                    end else begin
                        k = K_W'((longint'(elapsed) << FB) / move_time);
                    end
                    b         = quintic_blend(k);
                    cmd_l     = blend_axis(traj_from_l, traj_goal_l, b);
                    cmd_r     = blend_axis(traj_from_r, traj_goal_r, b);
                    rsp.fresh = 1'b1;
                    if (k == P_ONE) begin
                        traj_run = 1'b0;
                        moves_finished++;
                    end
                end else begin
                    rsp.status = ST_NOTHING;
                end
            end
            OP_START: begin
                if (r.allowed) begin
                    traj_goal_l = r.left;
                    traj_goal_r = r.right;
                    traj_from_l = cmd_l;
                    traj_from_r = cmd_r;
                    traj_t0     = r.now;
                    traj_run    = 1'b1;
                end else begin
                    rsp.status = ST_REJECT;
                end
            end
            OP_STOP: begin
                traj_run = 1'b0;
            end
            default: begin
                traj_from_l = '0;
                traj_from_r = '0;
                traj_goal_l = '0;
                traj_goal_r = '0;
                cmd_l       = '0;
                cmd_r       = '0;
                traj_run    = 1'b0;
            end
        endcase
        rsp.left    = cmd_l;
        rsp.right   = cmd_r;
        rsp.running = traj_run;
        return rsp;
    endfunction

    function automatic void add_row(t_op op, logic [TIME_W-1:0] now, t_angle l, t_angle r,
                                    logic ok, bit has_fixed, motion_rsp_t fixed_rsp);
        bringup_row_t row;
        row.req       = '{op, now, l, r, ok};
        row.has_fixed = has_fixed;
        row.fixed_rsp = fixed_rsp;
        bringup_rows.push_back(row);
    endfunction

    // Extremes, small moves around the present command, or anything
    function automatic t_angle rand_angle();
        case ($urandom_range(15))
            0: return ANG_MAX;
            1: return ANG_MIN;
            2: return '0;
            3: return cmd_l + t_angle'($urandom_range(255)) - 128;
            default: return t_angle'($urandom);
        endcase
    endfunction

    function automatic motion_req_t random_request();
        motion_req_t r;
        r.op      = t_op'($urandom_range(3));
        r.now     = $urandom;
        r.left    = rand_angle();
        r.right   = rand_angle();
        r.allowed = 1'($urandom_range(1));
        return r;
    endfunction

    // Time advance between ticks: mostly a fraction of the move, sometimes none or a jump
    function automatic logic [TIME_W-1:0] time_step();
        case ($urandom_range(9))
            0: return '0;
            1: return $urandom;
            default: return $urandom_range(1, (move_time >> 2) + 1);
        endcase
    endfunction

    // Present one transaction, wait for acceptance, record its expected result
    task automatic send_request(input motion_req_t r, input bit has_fixed,
                                input motion_rsp_t fixed_rsp, output motion_rsp_t rsp);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 11) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= r.op;
        i_now_ms       <= r.now;
        i_target_left  <= r.left;
        i_target_right <= r.right;
        i_move_allowed <= r.allowed;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        rsp = step_trajectory(r);
        pending_commands.push_back(has_fixed ? fixed_rsp : rsp);
        items_sent++;
    endtask

    // Move time is only changed once every result is back
    task automatic program_move_time(input t_mtime value);
        i_in_valid <= 1'b0;
        while (pending_commands.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        move_time = value;
        settings_used++;
    endtask

    // Mostly start-then-tick sequences with random content, some noise in between
    task automatic run_moves(input int quota);
        motion_req_t r;
        motion_rsp_t rsp;
        int          counted;
        int          ticks;
        counted = 0;
        while (counted < quota) begin
            if ($urandom_range(99) < 80) begin
                r         = random_request();
                r.op      = OP_START;
                r.now     = wall_ms;
                r.allowed = ($urandom_range(9) != 0);
                send_request(r, PREDICTED, '0, rsp);
                counted++;
                ticks = 0;
                while (traj_run && ticks < 16) begin
                    wall_ms += time_step();
                    r     = random_request();
                    r.now = wall_ms;
                    // now and then a run is stopped, cleared or redirected
                    if ($urandom_range(19) != 0) begin
                        r.op = OP_TICK;
                    end
                    send_request(r, PREDICTED, '0, rsp);
                    counted++;
                    ticks++;
                end
            end else begin
                r = random_request();
                send_request(r, PREDICTED, '0, rsp);
                if (rsp.status != ST_NOTHING) begin
                    counted++;
                end
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    endtask

    // Result checker and random output stall
    always @(posedge i_clk) begin
        motion_rsp_t want;
        motion_rsp_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_command_left, o_command_right, o_command_valid, o_running, o_status};
            if (pending_commands.size() == 0) begin
                errors++;
                $display("%0t: result transaction with none pending: %h", $time, got);
            end else begin
                want = pending_commands.pop_front();
                results_checked++;
                if (got.left !== want.left) begin
                    flag_mismatch("command_left", want.left, got.left);
                end
                if (got.right !== want.right) begin
                    flag_mismatch("command_right", want.right, got.right);
                end
                if (got.fresh !== want.fresh) begin
                    flag_mismatch("command_valid", 32'(want.fresh), 32'(got.fresh));
                end
                if (got.running !== want.running) begin
                    flag_mismatch("running", 32'(want.running), 32'(got.running));
                end
                if (got.status !== want.status) begin
                    flag_mismatch("status", 32'(want.status), 32'(got.status));
                end
            end
        end
        i_out_stall <= !no_idle && i_rst_n && ($urandom_range(99) < 11);
    end

    // Watchdog: any transaction on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        motion_rsp_t rsp;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_operation    <= OP_TICK;
        i_now_ms       <= '0;
        i_target_left  <= '0;
        i_target_right <= '0;
        i_move_allowed <= 1'b0;
        i_out_stall    <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        traj_from_l = '0;
        traj_from_r = '0;
        traj_goal_l = '0;
        traj_goal_r = '0;
        cmd_l       = '0;
        cmd_r       = '0;
        traj_t0     = '0;
        traj_run    = 1'b0;
        move_time   = MOVE_TIME_RESET;
        wall_ms     = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bring-up table at the reset move time of 2000 ms
        // idle tick, rejected start, stop and clear with nothing running
        add_row(OP_TICK, 32'd0, '0, '0, 1'b0, TYPED, '{'0, '0, 1'b0, 1'b0, ST_NOTHING});
        add_row(OP_START, 32'd1, ANG_MAX, ANG_MIN, 1'b0, TYPED,
                '{'0, '0, 1'b0, 1'b0, ST_REJECT});
        add_row(OP_STOP, 32'd2, '0, '0, 1'b1, TYPED, '{'0, '0, 1'b0, 1'b0, ST_OK});
        add_row(OP_CLEAR, 32'd3, ANG_MAX, ANG_MAX, 1'b1, TYPED,
                '{'0, '0, 1'b0, 1'b0, ST_OK});
        // full-scale move across the clock wrap
        add_row(OP_START, 32'hFFFF_FF00, ANG_MAX, ANG_MIN, 1'b1, TYPED,
                '{'0, '0, 1'b0, 1'b1, ST_OK});
        add_row(OP_TICK, 32'hFFFF_FF00, '0, '0, 1'b0, TYPED, '{'0, '0, 1'b1, 1'b1, ST_OK});
        add_row(OP_TICK, 32'h0000_0100, '0, '0, 1'b0, PREDICTED, '0);
        add_row(OP_TICK, 32'h0000_02E8, '0, '0, 1'b0, PREDICTED, '0);
        add_row(OP_TICK, 32'h0000_06CF, '0, '0, 1'b0, PREDICTED, '0);
        add_row(OP_TICK, 32'h0000_06D0, '0, '0, 1'b0, TYPED,
                '{ANG_MAX, ANG_MIN, 1'b1, 1'b0, ST_OK});
        add_row(OP_TICK, 32'h0000_0800, '0, '0, 1'b1, TYPED,
                '{ANG_MAX, ANG_MIN, 1'b0, 1'b0, ST_NOTHING});
        // back the other way, then a rejected start and a restart mid-run
        add_row(OP_START, 32'd100, ANG_MIN, ANG_MAX, 1'b1, TYPED,
                '{ANG_MAX, ANG_MIN, 1'b0, 1'b1, ST_OK});
        add_row(OP_TICK, 32'd1100, '0, '0, 1'b0, PREDICTED, '0);
        add_row(OP_TICK, 32'd1101, '0, '0, 1'b0, PREDICTED, '0);
        add_row(OP_START, 32'd1200, '0, '0, 1'b0, PREDICTED, '0);
        add_row(OP_START, 32'd1300, 32'sh0001_0000, -32'sh0001_0000, 1'b1, PREDICTED, '0);
        add_row(OP_TICK, 32'd1800, '0, '0, 1'b0, PREDICTED, '0);
        // stop keeps the commands
        add_row(OP_STOP, 32'd1900, '0, '0, 1'b0, PREDICTED, '0);
        add_row(OP_TICK, 32'd1950, '0, '0, 1'b0, PREDICTED, '0);
        // wrapped elapsed time saturates at once
        add_row(OP_START, 32'd0, -32'sd1, 32'sd1, 1'b1, PREDICTED, '0);
        add_row(OP_TICK, 32'hFFFF_FFFF, '0, '0, 1'b0, TYPED,
                '{-32'sd1, 32'sd1, 1'b1, 1'b0, ST_OK});
        add_row(OP_START, 32'd10, 32'sh1234_5678, 32'shEDCB_A988, 1'b1, PREDICTED, '0);
        add_row(OP_TICK, 32'd710, '0, '0, 1'b0, PREDICTED, '0);
        // clear ends the run and zeroes everything
        add_row(OP_CLEAR, 32'd720, '0, '0, 1'b0, TYPED, '{'0, '0, 1'b0, 1'b0, ST_OK});
        add_row(OP_TICK, 32'd730, '0, '0, 1'b0, TYPED, '{'0, '0, 1'b0, 1'b0, ST_NOTHING});

        foreach (bringup_rows[i]) begin
            send_request(bringup_rows[i].req, bringup_rows[i].has_fixed,
                         bringup_rows[i].fixed_rsp, rsp);
        end

        // Random phases over several move times
        program_move_time('0);
        run_moves(60);
        program_move_time(16'd1);
        run_moves(70);
        program_move_time(16'hFFFF);
        run_moves(90);
        no_idle = 1'b1;
        program_move_time(t_mtime'($urandom_range(2, 30)));
        run_moves(90);
        program_move_time(16'd300);
        no_idle = 1'b0;
        run_moves(90);
        program_move_time(t_mtime'($urandom_range(31, 5000)));
        run_moves(90);
        program_move_time(MOVE_TIME_RESET);
        run_moves(60);

        // Drain
        i_in_valid <= 1'b0;
        while (pending_commands.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d transactions sent, %0d results checked, %0d moves ran to the end",
                 items_sent, results_checked, moves_finished);
        $display("tb: %0d move time settings written, among them 0, 1 and 65535",
                 settings_used);
        if (errors == 0 && pending_commands.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
